/* src/mel_pkg.sv */
// Shared types, codes and default sizes of the MIDI event looper.
package mel_pkg;

    localparam int EVENT_DEPTH_DEF = 256;
    localparam int TIME_BITS_DEF   = 16;
    localparam int BURST_MAX_DEF   = 64;

    localparam logic [3:0] TYPE_CC       = 4'hB;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

    localparam logic [6:0] CTL_RECORD = 7'd119;
    localparam logic [6:0] CTL_PLAY   = 7'd118;
    localparam logic [6:0] CTL_STOP   = 7'd117;

    localparam logic OP_MSG  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLOSE,
        S_RD,
        S_CHK
    } t_state;

    typedef struct packed {
        logic       op;
        logic [1:0] bytes_valid;
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
    } t_in;

    typedef struct packed {
        logic [7:0] out_status;
        logic [6:0] out_data_one;
        logic [6:0] out_data_two;
        logic       last;
        logic       dropped;
        logic [1:0] transport_mode;
    } t_out;

endpackage

/* src/midi_event_looper.sv */
// Top level of the MIDI event looper: transport sequencer, event store and playback walker.
//
// Usage: an item (a 3-byte MIDI message or a 1 ms tick) is taken on i_item at a
// rising edge where start is high and busy is low. Messages never produce results.
// While recording, non-transport messages are stored with the record time while the
// store has room, and held notes are tracked. Closing a take walks all 128 note
// numbers one per cycle, writing a note-off for each held note while the store has room.
// A tick in playback walks the event store from the read pointer through a single
// registered read port, rewinding to the start when the loop wraps. Each result beat
// is on o_result with o_strobe high for exactly one cycle; results trail the walk by one
// beat and the final beat of a tick, carrying last and dropped, is on the ports in the
// first cycle that busy is low. The receiver cannot stall, so results are never held back.
// Reset (synchronous, active low) returns to idle with an empty store; the store
// contents themselves are not cleared, since only written entries are ever read.
module midi_event_looper
    import mel_pkg::*;
#(
    parameter int EVENT_DEPTH = EVENT_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int BURST_MAX   = BURST_MAX_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    localparam int AW = $clog2(EVENT_DEPTH);
    localparam int CW = AW + 1;
    localparam int NW = $clog2(BURST_MAX + 1);
    localparam int EW = TIME_BITS + 22;

    localparam logic [CW-1:0]        DEPTH_C = CW'(EVENT_DEPTH);
    localparam logic [NW-1:0]        BURST_C = NW'(BURST_MAX);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

    // Event store: {time, status, data one, data two}.
    logic [EW-1:0] mem [EVENT_DEPTH];
    logic [EW-1:0] r_rdata;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic [127:0]  r_held, n_held;
    logic [TIME_BITS-1:0] r_rtime, n_rtime;
    logic [TIME_BITS-1:0] r_len, n_len;
    logic [TIME_BITS-1:0] r_pos, n_pos;
    logic [TIME_BITS-1:0] r_limit, n_limit;
    logic [CW-1:0] r_rp, n_rp;
    logic r_first, n_first;
    t_in  r_in, n_in;
    logic [6:0] r_note, n_note;
    logic r_after_play, n_after_play;
    logic r_all, n_all;
    logic [NW-1:0] r_n, n_n;
    logic r_drop, n_drop;
    t_out r_pend, n_pend;
    logic r_pend_v, n_pend_v;
    t_out r_out, n_out;
    logic r_strobe, n_strobe;

    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          re;

    logic [3:0] msg_type;
    logic       is_cc, pressed, tctl;
    logic [TIME_BITS-1:0] len_eff;
    logic [TIME_BITS:0]   pos_inc;
    logic [TIME_BITS-1:0] ev_time;
    t_out ev_out;

    assign msg_type = r_in.status_byte[7:4];
    assign is_cc    = (msg_type == TYPE_CC);
    assign pressed  = is_cc && (r_in.data_two != 7'd0);
    assign tctl     = is_cc && (r_in.data_one == CTL_RECORD || r_in.data_one == CTL_PLAY
                                || r_in.data_one == CTL_STOP);
    assign len_eff  = (r_len == '0) ? TIME_ONE : r_len;
    assign pos_inc  = {1'b0, r_pos} + (TIME_BITS + 1)'(1);
    assign ev_time  = r_rdata[EW-1:22];

    always_comb begin
        ev_out.out_status     = r_rdata[21:14];
        ev_out.out_data_one   = r_rdata[13:7];
        ev_out.out_data_two   = r_rdata[6:0];
        ev_out.last           = 1'b0;
        ev_out.dropped        = 1'b0;
        ev_out.transport_mode = MODE_PLAY;
    end

    always_comb begin
        n_state = r_state;
        n_mode = r_mode;
        n_count = r_count;
        n_held = r_held;
        n_rtime = r_rtime;
        n_len = r_len;
        n_pos = r_pos;
        n_limit = r_limit;
        n_rp = r_rp;
        n_first = r_first;
        n_in = r_in;
        n_note = r_note;
        n_after_play = r_after_play;
        n_all = r_all;
        n_n = r_n;
        n_drop = r_drop;
        n_pend = r_pend;
        n_pend_v = r_pend_v;
        n_out = r_out;
        n_strobe = 1'b0;
        we = 1'b0;
        waddr = r_count[AW-1:0];
        wdata = {r_rtime, r_in.status_byte, r_in.data_one, r_in.data_two};
        re = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (r_in.op == OP_MSG) begin
                    if (r_in.bytes_valid == 2'd3) begin
                        if (pressed && r_in.data_one == CTL_RECORD) begin
                            if (r_mode != MODE_REC) begin
                                n_mode = MODE_REC;
                                n_count = '0;
                                n_rtime = '0;
                                n_held = '0;
                            end else begin
                                n_len = (r_rtime == '0) ? TIME_ONE : r_rtime;
                                n_after_play = 1'b1;
                                n_note = 7'd0;
                                n_state = S_CLOSE;
                            end
                        end else if (pressed && r_in.data_one == CTL_PLAY) begin
                            if (r_mode == MODE_IDLE && r_count != '0) begin
                                n_mode = MODE_PLAY;
                                n_pos = '0;
                                n_rp = '0;
                                n_first = 1'b1;
                            end
                        end else if (pressed && r_in.data_one == CTL_STOP) begin
                            if (r_mode == MODE_REC) begin
                                n_len = (r_rtime == '0) ? TIME_ONE : r_rtime;
                                n_after_play = 1'b0;
                                n_note = 7'd0;
                                n_state = S_CLOSE;
                            end else begin
                                n_mode = MODE_IDLE;
                            end
                        end else if (r_mode == MODE_REC && !tctl) begin
                            if (msg_type == TYPE_NOTE_ON && r_in.data_two != 7'd0) begin
                                n_held[r_in.data_one] = 1'b1;
                            end else if (msg_type == TYPE_NOTE_ON
                                         || msg_type == TYPE_NOTE_OFF) begin
                                n_held[r_in.data_one] = 1'b0;
                            end
                            if (r_count < DEPTH_C) begin
                                we = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                    end
                end else if (r_mode == MODE_REC) begin
                    if (r_rtime < TIME_MAX) begin
                        n_rtime = r_rtime + TIME_ONE;
                    end
                end else if (r_mode == MODE_PLAY) begin
                    n_n = '0;
                    n_drop = 1'b0;
                    n_pend_v = 1'b0;
                    n_state = S_RD;
                    n_limit = '0;
                    n_all = 1'b0;
                    if (r_first) begin
                        n_first = 1'b0;
                        n_pos = '0;
                    end else if (pos_inc >= {1'b0, len_eff}) begin
                        n_all = 1'b1;
                        n_pos = '0;
                    end else begin
                        n_limit = pos_inc[TIME_BITS-1:0];
                        n_pos = pos_inc[TIME_BITS-1:0];
                    end
                end
            end
            S_CLOSE: begin
                // One note number per cycle, lowest first.
                wdata = {r_len, STATUS_NOTE_OFF, r_note, 7'd0};
                if (r_held[r_note] && r_count < DEPTH_C) begin
                    we = 1'b1;
                    n_count = r_count + CW'(1);
                end
                n_held[r_note] = 1'b0;
                n_note = r_note + 7'd1;
                if (r_note == 7'd127) begin
                    n_state = S_IDLE;
                    if (r_after_play) begin
                        n_mode = MODE_PLAY;
                        n_pos = '0;
                        n_rp = '0;
                        n_first = 1'b1;
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
            S_RD: begin
                if (r_rp < r_count) begin
                    re = 1'b1;
                    n_state = S_CHK;
                end else if (r_all) begin
                    // Wrap: rewind and collect the events at time zero.
                    n_all = 1'b0;
                    n_rp = '0;
                end else begin
                    n_state = S_IDLE;
                    if (r_pend_v) begin
                        n_out = r_pend;
                        n_out.last = 1'b1;
                        n_out.dropped = r_drop;
                        n_strobe = 1'b1;
                        n_pend_v = 1'b0;
                    end
                end
            end
            S_CHK: begin
                if (r_all || ev_time <= r_limit) begin
                    if (r_n < BURST_C) begin
                        if (r_pend_v) begin
                            n_out = r_pend;
                            n_strobe = 1'b1;
                        end
                        n_pend = ev_out;
                        n_pend_v = 1'b1;
                        n_n = r_n + NW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_rp = r_rp + CW'(1);
                    n_state = S_RD;
                end else begin
                    n_state = S_IDLE;
                    if (r_pend_v) begin
                        n_out = r_pend;
                        n_out.last = 1'b1;
                        n_out.dropped = r_drop;
                        n_strobe = 1'b1;
                        n_pend_v = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[r_rp[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_pend <= n_pend;
        r_out <= n_out;
        r_limit <= n_limit;
        r_note <= n_note;
        r_after_play <= n_after_play;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= MODE_IDLE;
            r_count <= '0;
            r_held <= '0;
            r_rtime <= '0;
            r_len <= '0;
            r_pos <= '0;
            r_rp <= '0;
            r_first <= 1'b0;
            r_all <= 1'b0;
            r_n <= '0;
            r_drop <= 1'b0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode <= n_mode;
            r_count <= n_count;
            r_held <= n_held;
            r_rtime <= n_rtime;
            r_len <= n_len;
            r_pos <= n_pos;
            r_rp <= n_rp;
            r_first <= n_first;
            r_all <= n_all;
            r_n <= n_n;
            r_drop <= n_drop;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_strobe_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.transport_mode == MODE_PLAY)
        else $error("result beat outside playback");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("event count beyond store depth");
    a_close_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLOSE |-> r_mode == MODE_REC)
        else $error("take closing while not recording");
    a_walk_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CHK) |-> r_mode == MODE_PLAY)
        else $error("event walk while not playing");
`endif

endmodule
